// ===== hw/rtl/periodic_task_timer_table_top_defines.svh =====
// Assertion macros for the periodic task timer table.
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PTT_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define PTT_ASSERT(label, prop, msg)
`define PTT_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/ptt_pkg.sv =====
// Shared constants, types and functions of the periodic task timer table.
package ptt_pkg;

	localparam int TASKS       = 16;
	localparam int TIME_BITS   = 48;
	localparam int PERIOD_BITS = 32;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = 4;
	localparam int STAT_W      = 2;
	localparam int CNT_BITS    = $clog2(TASKS + 1);
	localparam int N_BITS      = $clog2(MAX_RESULTS + 1);

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [STAT_W-1:0] STAT_ADDED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FIRED = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NONE  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// broadcast to every cell
	typedef struct packed {
		logic                   load;
		logic                   step;
		logic                   wr_en;
		logic [TIME_BITS-1:0]   now;
		logic [TIME_BITS-1:0]   wr_deadline;
		logic [PERIOD_BITS-1:0] wr_period;
	} cell_ctl_t;

	// saturates at the largest time
	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] base,
			input logic [PERIOD_BITS-1:0] inc);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, base} + (TIME_BITS + 1)'(inc);
		return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/ptt_if.sv =====
// Input and result channel interfaces of the periodic task timer table.
interface ptt_req_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [ptt_pkg::PERIOD_BITS-1:0] interval;
	logic [ptt_pkg::TIME_BITS-1:0]   now_time;

	modport source (output valid, kind, interval, now_time, input ready);
	modport sink (input valid, kind, interval, now_time, output ready);
endinterface

interface ptt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ptt_pkg::STAT_W-1:0] status;
	logic [ptt_pkg::IDX_W-1:0]  task_index;
	logic                       last;

	modport source (output valid, status, task_index, last, input ready);
	modport sink (input valid, status, task_index, last, output ready);
endinterface

// ===== hw/rtl/ptt_cell.sv =====
// One table cell: deadline and period of a task, plus the scan token.
module ptt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ptt_pkg::cell_ctl_t ctl,
	input  logic               head,
	input  logic               wr_sel,
	input  logic               token_in,
	output logic               token_out,
	output logic               due
);
	import ptt_pkg::*;

	logic                   token_q;
	logic [TIME_BITS-1:0]   deadline_q;
	logic [PERIOD_BITS-1:0] period_q;

	// only the cell holding the token reports
	assign due       = token_q && (deadline_q <= ctl.now);
	assign token_out = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else if (ctl.load) begin
			token_q <= head;
		end else if (ctl.step) begin
			token_q <= token_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && wr_sel) begin
			deadline_q <= ctl.wr_deadline;
			period_q   <= ctl.wr_period;
		end else if (ctl.step && due) begin
			deadline_q <= sat_add(deadline_q, period_q);
		end
	end

endmodule

// ===== hw/rtl/periodic_task_timer_table_top.sv =====
// Periodic task timer table: a token walks a row of task cells on each tick.
// Add: the result is registered in the cycle after accept, next item taken as the result leaves.
// Tick: a load step, a scan step per task in use, then a closing step;
// a stalled result stalls the token walk.
// Reset clears the task count and control state; cell contents are written
// by adds before they are ever read, so no clearing pass.
`include "periodic_task_timer_table_top_defines.svh"

module periodic_task_timer_table_top (
	input  logic  clk,
	input  logic  arst_n,
	ptt_req_if.sink   req,
	ptt_rsp_if.source rsp
);
	import ptt_pkg::*;

	localparam logic [CNT_BITS-1:0] TASKS_C = CNT_BITS'(TASKS);
	localparam logic [N_BITS-1:0]   MAX_C   = N_BITS'(MAX_RESULTS);

	state_t               state_q, state_d;
	logic [CNT_BITS-1:0]  task_total_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic [CNT_BITS-1:0]  idx_next;
	logic [N_BITS-1:0]    n_q;
	logic [N_BITS-1:0]    n_next;
	logic                 pend_v_q;
	logic [CNT_BITS-1:0]  pend_idx_q;
	logic [TIME_BITS-1:0] now_q;

	logic                 out_v_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 req_ready;
	logic                 emit;
	logic [STAT_W-1:0]    emit_status;
	logic [IDX_W-1:0]     emit_idx;
	logic                 emit_last;
	logic                 fired;
	logic                 pend_clr;
	cell_ctl_t            ctl;

	logic [TASKS-1:0]     tok;
	logic [TASKS-1:0]     due;
	logic [TASKS-1:0]     wr_sel;

	genvar gi;
	generate
		for (gi = 0; gi < TASKS; gi++) begin : g_cell
			logic tok_in;
			if (gi == 0) begin : g_head
				assign tok_in = 1'b0;
			end else begin : g_body
				assign tok_in = tok[gi-1];
			end
			assign wr_sel[gi] = (task_total_q == CNT_BITS'(gi));
			ptt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.head      (gi == 0),
				.wr_sel    (wr_sel[gi]),
				.token_in  (tok_in),
				.token_out (tok[gi]),
				.due       (due[gi])
			);
		end
	endgenerate

	assign fired    = |due;
	assign out_free = !out_v_q || rsp.ready;
	assign idx_next = idx_q + 1'b1;
	assign n_next   = fired ? n_q + 1'b1 : n_q;

	assign req.ready      = req_ready;
	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.task_index = out_idx_q;
	assign rsp.last       = out_last_q;

	always_comb begin
		state_d         = state_q;
		req_ready       = 1'b0;
		emit            = 1'b0;
		emit_status     = STAT_NONE;
		emit_idx        = '0;
		emit_last       = 1'b0;
		pend_clr        = 1'b0;
		ctl.load        = 1'b0;
		ctl.step        = 1'b0;
		ctl.wr_en       = 1'b0;
		ctl.now         = now_q;
		ctl.wr_deadline = sat_add(req.now_time, req.interval);
		ctl.wr_period   = req.interval;
		case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				if (req.valid && out_free) begin
					if (req.kind == KIND_ADD) begin
						emit      = 1'b1;
						emit_last = 1'b1;
						if (task_total_q >= TASKS_C) begin
							emit_status = STAT_FULL;
						end else begin
							emit_status = STAT_ADDED;
							emit_idx    = IDX_W'(task_total_q);
							ctl.wr_en   = 1'b1;
						end
					end else begin
						ctl.load = 1'b1;
						state_d  = (task_total_q == '0) ? ST_FINISH : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (out_free) begin
					ctl.step = 1'b1;
					// a held hit is not the final one once another follows
					if (fired && pend_v_q) begin
						emit        = 1'b1;
						emit_status = STAT_FIRED;
						emit_idx    = IDX_W'(pend_idx_q);
					end
					if (idx_next >= task_total_q || n_next >= MAX_C) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					pend_clr  = 1'b1;
					if (pend_v_q) begin
						emit_status = STAT_FIRED;
						emit_idx    = IDX_W'(pend_idx_q);
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			task_total_q <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.wr_en) begin
				task_total_q <= task_total_q + 1'b1;
			end
			if (ctl.load) begin
				idx_q    <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end else if (ctl.step) begin
				idx_q <= idx_next;
				n_q   <= n_next;
				if (fired) begin
					pend_v_q <= 1'b1;
				end
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			now_q <= req.now_time;
		end
		if (ctl.step && fired) begin
			pend_idx_q <= idx_q;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_idx_q    <= emit_idx;
			out_last_q   <= emit_last;
		end
	end

	`PTT_ASSERT_IMPL(a_ready_idle, req_ready, state_q == ST_IDLE, "input taken outside idle")
	`PTT_ASSERT_IMPL(a_scan_token, state_q == ST_SCAN, $onehot(tok), "scan token lost")
	`PTT_ASSERT(a_token_single, $onehot0(tok), "more than one scan token")
	`PTT_ASSERT(a_total_bound, task_total_q <= TASKS_C, "task count beyond table size")
	`PTT_ASSERT_IMPL(a_fire_bound, ctl.step, n_q < MAX_C, "scan stepped past result cap")

endmodule
